// File: src/nco_pkg.sv
// Shared types, constants and the quarter-wave sine table generator for the
// numerically controlled oscillator. No dependencies.
package nco_pkg;

  localparam int TABLE_ADDR_BITS_DEF = 10;
  localparam int SINE_BITS_DEF       = 16;

  localparam logic [31:0]        HZ_TO_STEP_RESET = 32'd399000000;
  localparam logic signed [15:0] AMPLITUDE_RESET  = 16'sd819;
  localparam logic [63:0]        HALF_PI_Q30      = 64'd1686629713;
  localparam int                 STEP_SHIFT       = 24;

  // Payload of one input transfer, phase in the lowest bits.
  typedef struct packed {
    logic signed [15:0] amplitude;
    logic [31:0]        frequency;
    logic [31:0]        phase;
  } nco_values_t;

  // Load strobes of one input transfer, load_phase in the lowest bit.
  typedef struct packed {
    logic load_amplitude;
    logic load_frequency;
    logic load_phase;
  } nco_load_t;

  // Control and side data that travel with the table read.
  typedef struct packed {
    logic               valid;
    logic               negate;
    logic signed [15:0] amp;
  } nco_stage_t;

  // One quarter-wave entry: sine at the middle of bin idx, scaled to the
  // peak code, via a Q30 Taylor series with truncating products.
  function automatic logic [31:0] sine_entry(input int unsigned idx,
                                             input int unsigned addr_bits,
                                             input int unsigned sine_bits);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic signed [63:0] peak;
    logic signed [63:0] s;
    x    = (HALF_PI_Q30 * 64'(2 * idx + 1)) >> (addr_bits + 1);
    x2   = (x * x) >> 30;
    term = x;
    sum  = signed'(x);
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + signed'(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + signed'(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + signed'(term);
    term = ((term * x2) >> 30) / 64'd210;
    sum  = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd272;
    sum  = sum + signed'(term);
    peak = (64'sd1 <<< (sine_bits - 1)) - 64'sd1;
    s    = (sum < 0) ? 64'sd0 : sum;
    return 32'((s * peak + (64'sd1 <<< 29)) >>> 30);
  endfunction

endpackage

// File: src/nco_phase.sv
// Oscillator state: phase accumulator, frequency, amplitude, hz_to_step
// register and the registered phase-step multiplier. Depends on nco_pkg.
module nco_phase (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [31:0]                cfg_wdata,
  input  logic                       accept,
  input  nco_pkg::nco_load_t         load,
  input  nco_pkg::nco_values_t       values,
  output logic [31:0]                phase,
  output logic signed [15:0]         amplitude
);
  import nco_pkg::*;

  logic [31:0]        hz_r;
  logic [31:0]        freq_r;
  logic [31:0]        freq_nxt;
  logic signed [15:0] amp_r;
  logic [31:0]        base_r;
  logic [31:0]        step_r;
  logic [31:0]        step_nxt;
  logic [63:0]        prod;

  // The step of the previous transfer is added only when the next one
  // arrives, so the multiplier has a register behind it.
  assign phase     = load.load_phase ? values.phase : base_r + step_r;
  assign freq_nxt  = load.load_frequency ? values.frequency : freq_r;
  assign amplitude = load.load_amplitude ? values.amplitude : amp_r;
  assign prod      = freq_nxt * hz_r;
  assign step_nxt  = prod[STEP_SHIFT +: 32];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hz_r   <= HZ_TO_STEP_RESET;
      freq_r <= '0;
      amp_r  <= AMPLITUDE_RESET;
      base_r <= '0;
      step_r <= '0;
    end else begin
      if (cfg_we) begin
        hz_r <= cfg_wdata;
      end
      if (accept) begin
        freq_r <= freq_nxt;
        amp_r  <= amplitude;
        base_r <= phase;
        step_r <= step_nxt;
      end
    end
  end

endmodule

// File: src/nco_sine_rom.sv
// Quarter-wave sine table with quadrant folding and a registered read.
// Depends on nco_pkg for the table generator and the stage struct.
module nco_sine_rom #(
  parameter int TABLE_ADDR_BITS = nco_pkg::TABLE_ADDR_BITS_DEF,
  parameter int SINE_BITS       = nco_pkg::SINE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv,
  input  logic                       accept,
  input  logic [31:0]                phase,
  input  logic signed [15:0]         amplitude,
  output nco_pkg::nco_stage_t        stage,
  output logic [SINE_BITS-2:0]       mag
);
  import nco_pkg::*;

  localparam int DEPTH = 1 << TABLE_ADDR_BITS;
  localparam int MAG_W = SINE_BITS - 1;

  logic [MAG_W-1:0]           rom [DEPTH];
  logic [1:0]                 quad;
  logic [TABLE_ADDR_BITS-1:0] idx;
  logic [TABLE_ADDR_BITS-1:0] addr;
  logic [MAG_W-1:0]           mag_r;
  logic                       valid_r;
  logic                       negate_r;
  logic signed [15:0]         amp_r;

  for (genvar g = 0; g < DEPTH; g++) begin : g_rom
    assign rom[g] = MAG_W'(sine_entry(g, TABLE_ADDR_BITS, SINE_BITS));
  end

  // Odd quadrants run the table backwards; the upper half negates.
  assign quad = phase[31:30];
  assign idx  = phase[29 -: TABLE_ADDR_BITS];
  assign addr = quad[0] ? ~idx : idx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mag_r    <= rom[addr];
      negate_r <= quad[1];
      amp_r    <= amplitude;
    end
  end

  assign stage = '{valid: valid_r, negate: negate_r, amp: amp_r};
  assign mag   = mag_r;

endmodule

// File: src/nco_scale.sv
// Amplitude multiply, round half up and saturation to 16 bits, with the
// output register. Depends on nco_pkg for the stage struct.
module nco_scale #(
  parameter int SINE_BITS = nco_pkg::SINE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv,
  input  nco_pkg::nco_stage_t        stage,
  input  logic [SINE_BITS-2:0]       mag,
  output logic                       out_valid,
  output logic signed [15:0]         out_sample
);
  import nco_pkg::*;

  localparam int PW = 16 + SINE_BITS;
  localparam int RW = PW + 1;
  localparam logic signed [RW-1:0] RND_HALF = RW'(1) << (SINE_BITS - 2);
  localparam logic signed [RW-1:0] SAT_MAX  = RW'(32767);
  localparam logic signed [RW-1:0] SAT_MIN  = -RW'(32768);

  logic signed [SINE_BITS-1:0] sine;
  logic signed [PW-1:0]        prod_nxt;
  logic signed [PW-1:0]        prod_r;
  logic                        v2_r;
  logic signed [RW-1:0]        rnd;
  logic signed [RW-1:0]        q;
  logic signed [15:0]          sample_nxt;
  logic signed [15:0]          sample_r;
  logic                        valid_r;

  assign sine     = stage.negate ? -signed'({1'b0, mag}) : signed'({1'b0, mag});
  assign prod_nxt = PW'(stage.amp) * PW'(sine);

  // An arithmetic shift of the biased product is the floor division.
  assign rnd = RW'(prod_r) + RND_HALF;
  assign q   = rnd >>> (SINE_BITS - 1);

  always_comb begin
    if (q > SAT_MAX) begin
      sample_nxt = 16'sh7fff;
    end else if (q < SAT_MIN) begin
      sample_nxt = -16'sh8000;
    end else begin
      sample_nxt = q[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r    <= 1'b0;
      valid_r <= 1'b0;
    end else if (adv) begin
      v2_r    <= stage.valid;
      valid_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r   <= prod_nxt;
      sample_r <= sample_nxt;
    end
  end

  assign out_valid  = valid_r;
  assign out_sample = sample_r;

endmodule

// File: src/sine_oscillator_with_modulation_core.sv
// Numerically controlled sine oscillator with phase, frequency and amplitude
// loads per tick. Usage:
//   Each transfer on the in_ channel is one sample tick; it yields exactly
//   one transfer on the out_ channel carrying amplitude * sin(phase).
//   in_tuser strobes load the phase, frequency or amplitude from in_tdata,
//   and a load applies to the sample of the same tick. After the sample the
//   phase advances by (frequency * hz_to_step) >> 24.
//   cfg_we writes hz_to_step; write it only while no tick is in flight.
// Throughput: one tick per clock cycle while out_tready does not stall the output.
// Pipeline: a tick passes through the registered table read and the
//   registered amplitude multiply into the output register, whose sample
//   is then presented with out_tvalid.
// Reset: rst_n clears the pipeline, zeroes phase and frequency, sets the
//   amplitude to 819 and hz_to_step to 399000000. No table clearing is
//   needed; the sine table is a constant ROM.
// Stall: when out_tready is low with a sample waiting, the whole pipeline
//   holds and in_tready drops in the same cycle; no sample is dropped.
// Depends on nco_pkg, nco_phase, nco_sine_rom and nco_scale.
module sine_oscillator_with_modulation_core #(
  parameter int TABLE_ADDR_BITS = nco_pkg::TABLE_ADDR_BITS_DEF,
  parameter int SINE_BITS       = nco_pkg::SINE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,      // hz_to_step
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,       // phase_value, frequency_value, amplitude_value
  input  logic [2:0]  in_tuser,       // load_phase, load_frequency, load_amplitude
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata       // sample
);
  import nco_pkg::*;

  logic               adv;
  logic               accept;
  nco_values_t        values;
  nco_load_t          load;
  logic [31:0]        phase;
  logic signed [15:0] amplitude;
  nco_stage_t         stage;
  logic [SINE_BITS-2:0] mag;
  logic signed [15:0] sample;

  // The pipeline moves whenever the output register is empty or drained.
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;
  assign accept    = in_tvalid && adv;
  assign values    = nco_values_t'(in_tdata);
  assign load      = nco_load_t'(in_tuser);

  nco_phase u_phase (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .load      (load),
    .values    (values),
    .phase     (phase),
    .amplitude (amplitude)
  );

  nco_sine_rom #(
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
    .SINE_BITS       (SINE_BITS)
  ) u_rom (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .accept    (accept),
    .phase     (phase),
    .amplitude (amplitude),
    .stage     (stage),
    .mag       (mag)
  );

  nco_scale #(
    .SINE_BITS (SINE_BITS)
  ) u_scale (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .stage      (stage),
    .mag        (mag),
    .out_valid  (out_tvalid),
    .out_sample (sample)
  );

  assign out_tdata = sample;

endmodule

// File: src/nco_checker.sv
// Port-level checks for the oscillator core, bound to the top level.
// Sees only the top-level ports; no package dependency.
module nco_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  // A waiting sample stays until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output sample withdrawn before transfer");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("output sample changed while stalled");

  // The input side is only held back by a stalled output.
  a_ready_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow output backpressure");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind sine_oscillator_with_modulation_core nco_checker u_nco_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// File: test/sine_oscillator_with_modulation_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for sine_oscillator_with_modulation_core: directed
// and random ticks are checked against a sample predictor built into the bench.
// Depends on nco_pkg and the oscillator RTL.

module sine_oscillator_with_modulation_core_tb;
  import nco_pkg::*;

  localparam int ADDR_BITS   = TABLE_ADDR_BITS_DEF;
  localparam int SAMPLE_BITS = SINE_BITS_DEF;
  localparam int TABLE_SIZE  = 1 << ADDR_BITS;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 134;

  localparam nco_load_t LOAD_NONE  = '{load_amplitude: 1'b0, load_frequency: 1'b0,
                                       load_phase: 1'b0};
  localparam nco_load_t LOAD_PHASE = '{load_amplitude: 1'b0, load_frequency: 1'b0,
                                       load_phase: 1'b1};
  localparam nco_load_t LOAD_FREQ  = '{load_amplitude: 1'b0, load_frequency: 1'b1,
                                       load_phase: 1'b0};
  localparam nco_load_t LOAD_AMP   = '{load_amplitude: 1'b1, load_frequency: 1'b0,
                                       load_phase: 1'b0};
  localparam nco_load_t LOAD_ALL   = '{load_amplitude: 1'b1, load_frequency: 1'b1,
                                       load_phase: 1'b1};

  localparam logic signed [15:0] AMP_MAX = 16'sh7FFF;
  localparam logic signed [15:0] AMP_MIN = 16'sh8000;

  // Tracks oscillator state and holds the samples still owed by the block.
  class sample_predictor;
    logic [31:0]        step_scale;
    logic [31:0]        phase;
    logic [31:0]        freq;
    logic signed [15:0] amp;
    int                 quarter_table[TABLE_SIZE];
    logic signed [15:0] expected_samples[$];
    int                 errors;

    function new();
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint          sum;
      longint          peak;
      peak = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
      for (int i = 0; i < TABLE_SIZE; i++) begin
        // Angle at the middle of bin i, Q30 radians; Taylor series in Q30.
        x    = (HALF_PI_Q30 * 64'(2 * i + 1)) >> (ADDR_BITS + 1);
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (int k = 1; k <= 8; k++) begin
          term = (term * x2) >> 30;
          term = term / 64'((2 * k) * (2 * k + 1));
          if (k % 2 == 1) begin
            sum = sum - longint'(term);
          end else begin
            sum = sum + longint'(term);
          end
        end
        if (sum < 0) begin
          sum = 0;
        end
        quarter_table[i] = int'((sum * peak + (64'sd1 <<< 29)) >>> 30);
      end
      step_scale = HZ_TO_STEP_RESET;
      phase      = '0;
      freq       = '0;
      amp        = AMPLITUDE_RESET;
      errors     = 0;
    endfunction

    function void note_tick(input nco_load_t ld, input nco_values_t v);
      logic [ADDR_BITS-1:0] idx;
      logic [63:0]          prod;
      int                   sine;
      longint               q;
      if (ld.load_phase) begin
        phase = v.phase;
      end
      if (ld.load_frequency) begin
        freq = v.frequency;
      end
      if (ld.load_amplitude) begin
        amp = v.amplitude;
      end
      // Odd quadrants read the table mirrored, the lower half plane negates.
      idx = phase[29 -: ADDR_BITS];
      if (phase[30]) begin
        idx = ~idx;
      end
      sine = quarter_table[idx];
      if (phase[31]) begin
        sine = -sine;
      end
      q = (longint'(amp) * sine + (64'sd1 <<< (SAMPLE_BITS - 2))) >>> (SAMPLE_BITS - 1);
      if (q > 32767) begin
        q = 32767;
      end
      if (q < -32768) begin
        q = -32768;
      end
      expected_samples.push_back(16'(q));
      prod  = 64'(freq) * 64'(step_scale);
      phase = phase + 32'(prod >> STEP_SHIFT);
    endfunction

    function void check_sample(input logic signed [15:0] got);
      logic signed [15:0] want;
      if (expected_samples.size() == 0) begin
        $error("sample: expected none, actual %0d", got);
        errors++;
        return;
      end
      want = expected_samples.pop_front();
      if (got !== want) begin
        $error("sample: expected %0d, actual %0d", want, got);
        errors++;
      end
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_we     = 1'b0;
  logic [31:0] cfg_wdata  = '0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  nco_values_t in_values  = '0;   // phase_value, frequency_value, amplitude_value
  nco_load_t   in_loads   = '0;   // load_phase, load_frequency, load_amplitude
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;         // sample

  bit              send_idle = 1'b1;
  bit              rx_idle   = 1'b1;
  int              cycles    = 0;
  sample_predictor predicted;

  sine_oscillator_with_modulation_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_values),
    .in_tuser   (in_loads),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Receiver: ready most of the time, with stall bursts while rx_idle is set.
  always begin
    @(negedge clk);
    if (rx_idle && $urandom_range(0, 5) == 0) begin
      out_tready <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    out_tready <= 1'b1;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
    if (rst_n && in_tvalid && in_tready) begin
      predicted.note_tick(in_loads, in_values);
    end
    if (rst_n && out_tvalid && out_tready) begin
      predicted.check_sample(out_tdata);
    end
  end

  // Presents one tick and returns right after the edge that takes it.
  task automatic send_tick(input nco_load_t ld, input logic [31:0] ph,
                           input logic [31:0] fr, input logic [15:0] am);
    int gap;
    @(negedge clk);
    if (send_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 17);
      in_tvalid <= 1'b0;
      in_loads  <= nco_load_t'(3'($urandom()));
      in_values <= nco_values_t'({16'($urandom()), $urandom(), $urandom()});
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_loads  <= ld;
    in_values <= {am, fr, ph};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (predicted.expected_samples.size() != 0) @(posedge clk);
  endtask

  task automatic write_step_scale(input logic [31:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    predicted.step_scale = value;
  endtask

  // Waits for the block to go idle, sets a new step scale, then runs random ticks.
  task automatic run_phase(input int count, input logic [31:0] scale, input bit idling);
    nco_load_t          ld;
    logic [31:0]        fr;
    logic signed [15:0] am;
    drain();
    write_step_scale(scale);
    send_idle = idling;
    rx_idle   = idling;
    repeat (count) begin
      ld.load_phase     = ($urandom_range(0, 4) == 0);
      ld.load_frequency = ($urandom_range(0, 4) == 0);
      ld.load_amplitude = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 3))
        0:       fr = $urandom_range(0, 20000 << 12);
        1:       fr = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0;
        default: fr = $urandom();
      endcase
      case ($urandom_range(0, 5))
        0:       am = AMP_MIN;
        1:       am = AMP_MAX;
        default: am = 16'($urandom());
      endcase
      send_tick(ld, $urandom(), fr, am);
    end
  endtask

  initial begin
    predicted = new();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset state, quadrant boundaries, extreme amplitudes and frequencies.
    send_tick(LOAD_NONE, 32'h0, 32'h0, 16'h0);
    send_tick(LOAD_PHASE | LOAD_AMP, 32'h4000_0000, 32'h0, AMP_MAX);
    send_tick(LOAD_PHASE, 32'h3FFF_FFFF, 32'h0, 16'h0);
    send_tick(LOAD_PHASE, 32'h7FFF_FFFF, 32'h0, 16'h0);
    send_tick(LOAD_PHASE, 32'h8000_0000, 32'h0, 16'h0);
    send_tick(LOAD_PHASE, 32'hBFFF_FFFF, 32'h0, 16'h0);
    send_tick(LOAD_PHASE | LOAD_AMP, 32'hC000_0000, 32'h0, AMP_MIN);
    send_tick(LOAD_PHASE, 32'hFFFF_FFFF, 32'h0, 16'h0);
    send_tick(LOAD_AMP, 32'h0, 32'h0, 16'sd0);
    send_tick(LOAD_PHASE | LOAD_AMP, 32'h4000_0000, 32'h0, -16'sd1);
    send_tick(LOAD_AMP, 32'h0, 32'h0, 16'sd1);
    // All strobes at once, then let the phase wrap at full frequency.
    send_tick(LOAD_ALL, 32'h0, 32'hFFFF_FFFF, AMP_MAX);
    repeat (4) send_tick(LOAD_NONE, $urandom(), $urandom(), 16'($urandom()));
    send_tick(LOAD_FREQ, 32'h0, 32'h1, 16'h0);
    send_tick(LOAD_NONE, 32'h0, 32'h0, 16'h0);
    send_tick(LOAD_ALL, $urandom(), 32'd440 << 12, AMP_MIN);
    repeat (3) send_tick(LOAD_NONE, $urandom(), $urandom(), 16'($urandom()));
    send_tick(LOAD_FREQ, 32'h0, 32'h0, 16'h0);

    run_phase(PHASE_ITEMS, 32'hFFFF_FFFF, 1'b1);
    run_phase(PHASE_ITEMS, 32'h0, 1'b1);
    run_phase(PHASE_ITEMS, 32'h1, 1'b0);
    run_phase(PHASE_ITEMS, 32'h0100_0000, 1'b1);
    run_phase(PHASE_ITEMS, $urandom(), 1'b1);
    run_phase(PHASE_ITEMS, HZ_TO_STEP_RESET, 1'b0);

    drain();
    repeat (8) @(posedge clk);
    if (predicted.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: sim.f
src/nco_pkg.sv
src/nco_phase.sv
src/nco_sine_rom.sv
src/nco_scale.sv
src/sine_oscillator_with_modulation_core.sv
src/nco_checker.sv
test/sine_oscillator_with_modulation_core_tb.sv
